// File: sv/multi_motor_quadrature_edge_counter_assert.svh
// assertion macros used by the checker file
`ifndef MULTI_MOTOR_QUADRATURE_EDGE_COUNTER_ASSERT_SVH
`define MULTI_MOTOR_QUADRATURE_EDGE_COUNTER_ASSERT_SVH

// overlapping implication, disabled while reset is low
`define MMQEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mmqec assertion failed");

// implication checked in the next cycle, disabled while reset is low
`define MMQEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mmqec assertion failed");

`endif

// File: sv/mmqec_pkg.sv
// types, constants and helpers for the quadrature edge counter
`timescale 1ns / 1ps
package mmqec_pkg;

    localparam int NUM_SLOTS   = 4;   // active motor slots, 1 to 4
    localparam int COUNT_WIDTH = 32;  // width of the step counters, 8 to 64
    localparam int SLOT_FIELDS = 4;   // slots visible in registers and results
    localparam int OUT_WIDTH   = 32;  // width of each count in the result
    localparam int PIN_WIDTH   = 6;
    localparam int EDGE_WIDTH  = 2;
    localparam int CH_WIDTH    = 2;
    localparam int CFG_IDX_WIDTH = 4;
    localparam int NUM_REGS    = 2 * SLOT_FIELDS;

    typedef logic [PIN_WIDTH-1:0]          t_pin;
    typedef logic [EDGE_WIDTH-1:0]         t_edge;
    typedef logic [CH_WIDTH-1:0]           t_chan;
    typedef logic signed [COUNT_WIDTH-1:0] t_count;
    typedef logic signed [OUT_WIDTH-1:0]   t_out_count;

    localparam t_pin  PIN_NONE   = t_pin'(63);
    localparam t_chan CH_UNDEF   = t_chan'(0);
    localparam t_chan CH_A       = t_chan'(1);
    localparam t_chan CH_B       = t_chan'(2);
    localparam t_edge EDGE_UNDEF = t_edge'(3);

    // event handed to every slot, fire marks the cycle it is applied
    typedef struct packed {
        logic  fire;
        t_pin  pin;
        t_edge edge_kind;
    } t_event;

    // sign-extend or truncate a counter to the result width
    function automatic t_out_count count_to_out(input t_count c);
        return t_out_count'(c);
    endfunction

endpackage

// File: sv/mmqec_slot.sv
// one motor slot: pin match, direction decode and step counter
`timescale 1ns / 1ps
module mmqec_slot
    import mmqec_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_pin   i_pin_a,
    input  t_pin   i_pin_b,
    input  t_event i_evt,
    output logic   o_match,
    output t_count o_count
);

    t_chan  r_last_ch;
    t_edge  r_last_edge;
    t_count r_count;

    logic   w_is_a;
    logic   w_is_b;
    logic   w_same;
    logic   w_step;
    logic   w_fwd;
    t_chan  w_ch;

    always_comb begin
        w_is_a = (i_evt.pin != PIN_NONE) && (i_pin_a == i_evt.pin);
        w_is_b = !w_is_a && (i_evt.pin != PIN_NONE) && (i_pin_b == i_evt.pin);
        w_ch   = w_is_a ? CH_A : CH_B;
        w_same = (r_last_edge == i_evt.edge_kind);
        w_step = (r_last_ch != CH_UNDEF) && (r_last_ch != w_ch);
        // channel a steps forward on a changed edge, channel b on a repeated one
        w_fwd  = w_is_a ? !w_same : w_same;
    end

    assign o_match = w_is_a || w_is_b;
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ch   <= CH_UNDEF;
            r_last_edge <= EDGE_UNDEF;
            r_count     <= '0;
        end else if (i_evt.fire && o_match) begin
            r_last_ch   <= w_ch;
            r_last_edge <= i_evt.edge_kind;
            if (w_step) begin
                r_count <= w_fwd ? r_count + t_count'(1) : r_count - t_count'(1);
            end
        end
    end

endmodule

// File: sv/multi_motor_quadrature_edge_counter.sv
// top level of the multi-motor quadrature edge counter
//
//  channel     direction  handshake                         payload
//  s_axis      in         i_s_axis_tvalid / o_s_axis_tready  tdata: pin, tuser: edge kind
//  m_axis      out        o_m_axis_tvalid / i_m_axis_tready  tdata: four counts, slot mask
//  cfg         in         i_cfg_valid / o_cfg_ready          index, pin number
//
// one item per cycle sustained while the output is not stalled; a taken item
// passes the input register, then slot update and result register
// the slot update shares its cycle with the result load, so the next item always
// sees the counts left by the one before
// reset is synchronous, active low: pins unassigned, counts zero, no item held
// an output stall backs up into the input register, then drops o_s_axis_tready
`timescale 1ns / 1ps
module multi_motor_quadrature_edge_counter
    import mmqec_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // event input
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [7:0]               i_s_axis_tdata,   // [5:0] pin_number, [7:6] zero
    input  logic [1:0]               i_s_axis_tuser,   // [1:0] edge_kind
    // count output
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [135:0]             o_m_axis_tdata,   // [31:0] count_motor0,
                                                       // [63:32] count_motor1,
                                                       // [95:64] count_motor2,
                                                       // [127:96] count_motor3,
                                                       // [131:128] matched_slots,
                                                       // [135:132] zero
    // pin configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [PIN_WIDTH-1:0]     i_cfg_data
);

    // configured encoder pins per slot
    t_pin r_pin_a [SLOT_FIELDS];
    t_pin r_pin_b [SLOT_FIELDS];

    // input register
    logic  r_in_valid;
    logic  n_in_valid;
    t_pin  r_in_pin;
    t_edge r_in_edge;

    // result register (counts live in the slot counters)
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [SLOT_FIELDS-1:0] r_mask;

    logic                   w_advance;
    logic                   w_in_take;
    t_event                 w_evt;
    logic [SLOT_FIELDS-1:0] w_match;
    t_out_count             w_cnt [SLOT_FIELDS];

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_FIELDS; s++) begin
                r_pin_a[s] <= PIN_NONE;
                r_pin_b[s] <= PIN_NONE;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_WIDTH'(NUM_REGS))) begin
            // even index is channel a, odd is channel b; higher indexes ignored
            if (i_cfg_index[0]) begin
                r_pin_b[i_cfg_index[CFG_IDX_WIDTH-2:1]] <= i_cfg_data;
            end else begin
                r_pin_a[i_cfg_index[CFG_IDX_WIDTH-2:1]] <= i_cfg_data;
            end
        end
    end

    // handshake: held item moves on when the result register is free or emptying
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_pin  <= i_s_axis_tdata[PIN_WIDTH-1:0];
            r_in_edge <= i_s_axis_tuser;
        end
        if (w_advance) begin
            r_mask <= w_match;
        end
    end

    assign w_evt.fire      = w_advance;
    assign w_evt.pin       = r_in_pin;
    assign w_evt.edge_kind = r_in_edge;

    // active slots get a counter, the rest never match and read zero
    for (genvar s = 0; s < SLOT_FIELDS; s++) begin : g_slot
        if (s < NUM_SLOTS) begin : g_on
            t_count w_raw;
            mmqec_slot u_slot (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_pin_a (r_pin_a[s]),
                .i_pin_b (r_pin_b[s]),
                .i_evt   (w_evt),
                .o_match (w_match[s]),
                .o_count (w_raw)
            );
            assign w_cnt[s] = count_to_out(w_raw);
        end else begin : g_off
            assign w_match[s] = 1'b0;
            assign w_cnt[s]   = '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_mask, w_cnt[3], w_cnt[2], w_cnt[1], w_cnt[0]};

endmodule

// File: sv/mmqec_checker.sv
// port-level checks for the quadrature edge counter, bound to the top level
`timescale 1ns / 1ps
`include "multi_motor_quadrature_edge_counter_assert.svh"
module mmqec_checker
    import mmqec_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [135:0] o_m_axis_tdata
);

    logic w_out_take;
    assign w_out_take = o_m_axis_tvalid && i_m_axis_tready;

    // a stalled result holds still
    `MMQEC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // a stalled output with a full input side stops taking items
    `MMQEC_ASSERT_NEXT(a_backpressure, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready && !o_s_axis_tready, !o_s_axis_tready || i_m_axis_tready)

    // the result after a taken one reflects one event: unmatched slots 0 and 3 keep their count
    `MMQEC_ASSERT_NEXT(a_slot0_keep, i_clk, i_rst_n, w_out_take, !o_m_axis_tvalid || o_m_axis_tdata[128] || $stable(o_m_axis_tdata[31:0]))
    `MMQEC_ASSERT_NEXT(a_slot3_keep, i_clk, i_rst_n, w_out_take, !o_m_axis_tvalid || o_m_axis_tdata[131] || $stable(o_m_axis_tdata[127:96]))

endmodule

bind multi_motor_quadrature_edge_counter mmqec_checker u_mmqec_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
